FILE: hw/rtl/grid_orientation_fill_engine_defines.svh
// Assertion macros for the grid orientation fill engine.
`ifndef GRID_ORIENTATION_FILL_ENGINE_DEFINES_SVH
`define GRID_ORIENTATION_FILL_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define GOFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define GOFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gofe_pkg.sv
// Package for the grid orientation fill engine: sizes, codes and payload types.
package gofe_pkg;

  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int DIM_W    = SIDE_W + 1;
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_TRANSFORM = 2'd1;
  localparam logic [1:0] OP_FILL      = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic [2:0] TR_FWD         = 3'd0;
  localparam logic [2:0] TR_BACK        = 3'd1;
  localparam logic [2:0] TR_HALF        = 3'd2;
  localparam logic [2:0] TR_MIRROR      = 3'd3;
  localparam logic [2:0] TR_MIRROR_HALF = 3'd4;
  localparam logic [2:0] TR_HALF_ALT    = 3'd5;

  localparam logic REG_BASE_ROWS = 1'b0;
  localparam logic REG_BASE_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] transform_code;
    logic [5:0] row_first;
    logic [5:0] col_first;
    logic [5:0] row_last;
    logic [5:0] col_last;
    logic [7:0] cell_char;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [6:0] view_rows;
    logic [6:0] view_cols;
    logic       range_error;
  } out_t;

endpackage

FILE: hw/rtl/grid_orientation_fill_engine.sv
// Grid orientation fill engine: frame store with a rotate/mirror view, cell and fill access.
//
//   channel  signals                        transfer when
//   cmd      cmd_valid cmd_ready cmd        cmd_valid && cmd_ready
//   rsp      rsp_valid rsp_ready rsp_data   rsp_valid && rsp_ready
//   apb      psel penable pwrite paddr ...  psel && penable && pwrite (write)
//
// Write, transform and rejected commands: from transfer through S_EMIT to rsp_valid.
// Read: an extra S_READ_WAIT state for the registered frame store read port.
// Fill: S_FILL walks the cells, one store write per cell through the single port.
// One command is in flight at a time; cmd_ready is high only when idle.
// A stalled response holds the engine before it returns to idle.
// Reset clears the view and sets both sides to 64; the frame store is not cleared.
`include "grid_orientation_fill_engine_defines.svh"

module grid_orientation_fill_engine
  import gofe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  in_t         cmd,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output out_t        rsp_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {S_IDLE, S_READ_WAIT, S_FILL, S_EMIT} state_t;

  localparam logic [DIM_W-1:0] SIDE_MAX = DIM_W'(MAX_SIDE);
  localparam logic [DIM_W-1:0] SIDE_ONE = DIM_W'(1);

  function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_ONE;
    else if (v > SIDE_MAX) r = SIDE_MAX;
    return r;
  endfunction

  state_t            state;
  logic [6:0]        base_rows;
  logic [6:0]        base_cols;
  logic [1:0]        rot;
  logic              mir;
  logic [1:0]        rot_next;
  logic              mir_next;
  logic [SIDE_W-1:0] fill_row;
  logic [SIDE_W-1:0] fill_col;
  logic [SIDE_W-1:0] col_first_q;
  logic [SIDE_W-1:0] row_last_q;
  logic [SIDE_W-1:0] col_last_q;
  logic [7:0]        fill_char;
  logic [7:0]        hold_char;
  logic              hold_err;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  logic [DIM_W-1:0]  side_m;
  logic [DIM_W-1:0]  side_n;
  logic [DIM_W-1:0]  view_rows;
  logic [DIM_W-1:0]  view_cols;
  logic [SIDE_W-1:0] map_r;
  logic [SIDE_W-1:0] map_c;
  logic [DIM_W-1:0]  vr;
  logic [DIM_W-1:0]  vc;
  logic [DIM_W-1:0]  sr;
  logic [DIM_W-1:0]  sc;

  logic cmd_fire;
  logic cell_bad;
  logic fill_bad;
  logic fill_empty;
  logic cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_BASE_COLS) ? {25'd0, base_cols} : {25'd0, base_rows};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_rows <= 7'd64;
      base_cols <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE_ROWS) base_rows <= pwdata[6:0];
      else base_cols <= pwdata[6:0];
    end
  end

  assign side_m    = clamp_side(base_rows);
  assign side_n    = clamp_side(base_cols);
  assign view_rows = rot[0] ? side_n : side_m;
  assign view_cols = rot[0] ? side_m : side_n;

  assign cmd_ready  = (state == S_IDLE);
  assign cmd_fire   = cmd_valid && cmd_ready;
  assign cell_bad   = ({1'b0, cmd.row_first} >= view_rows) ||
                      ({1'b0, cmd.col_first} >= view_cols);
  assign fill_bad   = cell_bad || ({1'b0, cmd.row_last} >= view_rows) ||
                      ({1'b0, cmd.col_last} >= view_cols);
  assign fill_empty = (cmd.row_first > cmd.row_last) || (cmd.col_first > cmd.col_last);

  // view to storage remap, shared by the command cell and the fill walker
  always_comb begin
    map_r = (state == S_FILL) ? fill_row : cmd.row_first;
    map_c = (state == S_FILL) ? fill_col : cmd.col_first;
    vr    = mir ? (view_rows - SIDE_ONE - {1'b0, map_r}) : {1'b0, map_r};
    vc    = {1'b0, map_c};
    case (rot)
      2'd0: begin
        sr = vr;
        sc = vc;
      end
      2'd1: begin
        sr = side_m - SIDE_ONE - vc;
        sc = vr;
      end
      2'd2: begin
        sr = side_m - SIDE_ONE - vr;
        sc = side_n - SIDE_ONE - vc;
      end
      default: begin
        sr = vc;
        sc = side_n - SIDE_ONE - vr;
      end
    endcase
    mem_addr = {sr[SIDE_W-1:0], sc[SIDE_W-1:0]};
  end

  assign mem_we    = (cmd_fire && cmd.opcode == OP_WRITE && !cell_bad) || (state == S_FILL);
  assign mem_re    = cmd_fire && cmd.opcode == OP_READ && !cell_bad;
  assign mem_wdata = (state == S_FILL) ? fill_char : cmd.cell_char;

  // single port; commands are serialized so a read never meets a pending write
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  always_comb begin
    rot_next = rot;
    mir_next = mir;
    case (cmd.transform_code)
      TR_FWD:              rot_next = rot + (mir ? 2'd3 : 2'd1);
      TR_BACK:             rot_next = rot + (mir ? 2'd1 : 2'd3);
      TR_HALF, TR_HALF_ALT: rot_next = rot + 2'd2;
      TR_MIRROR:           mir_next = ~mir;
      TR_MIRROR_HALF: begin
        mir_next = ~mir;
        rot_next = rot + 2'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rot       <= 2'd0;
      mir       <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_EMIT) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            hold_char   <= 8'd0;
            fill_row    <= cmd.row_first;
            fill_col    <= cmd.col_first;
            col_first_q <= cmd.col_first;
            row_last_q  <= cmd.row_last;
            col_last_q  <= cmd.col_last;
            fill_char   <= cmd.cell_char;
            case (cmd.opcode)
              OP_TRANSFORM: begin
                hold_err <= 1'b0;
                state    <= S_EMIT;
                rot      <= rot_next;
                mir      <= mir_next;
              end
              OP_FILL: begin
                hold_err <= fill_bad;
                state    <= (fill_bad || fill_empty) ? S_EMIT : S_FILL;
              end
              OP_READ: begin
                hold_err <= cell_bad;
                state    <= cell_bad ? S_EMIT : S_READ_WAIT;
              end
              default: begin
                hold_err <= cell_bad;
                state    <= S_EMIT;
              end
            endcase
          end
        end
        S_READ_WAIT: begin
          hold_char <= rd_q;
          state     <= S_EMIT;
        end
        S_FILL: begin
          if (fill_col == col_last_q) begin
            if (fill_row == row_last_q) begin
              state <= S_EMIT;
            end else begin
              fill_row <= fill_row + SIDE_W'(1);
              fill_col <= col_first_q;
            end
          end else begin
            fill_col <= fill_col + SIDE_W'(1);
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp_data.read_char   <= hold_char;
            rsp_data.view_rows   <= view_rows;
            rsp_data.view_cols   <= view_cols;
            rsp_data.range_error <= hold_err;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GOFE_ASSERT_NOW(a_fill_in_view, state == S_FILL, ({1'b0, fill_row} < view_rows) && ({1'b0, fill_col} < view_cols), "fill walker left the view")
  `GOFE_ASSERT_NEXT(a_busy_after_cmd, cmd_fire, state != S_IDLE, "engine idle right after a command transfer")
  `GOFE_ASSERT_NEXT(a_rsp_drains, rsp_valid && rsp_ready && state != S_EMIT, !rsp_valid, "response repeated after transfer")
  `GOFE_ASSERT_NOW(a_no_write_on_read, state == S_READ_WAIT, !mem_we, "store write during read wait")

endmodule
